// File: sv/loc_pkg.sv
// Shared types and codes for the lock order checker.
package loc_pkg;

    // Operation codes carried on the input tuser.
    localparam logic [1:0] OP_ACQUIRE   = 2'd0;
    localparam logic [1:0] OP_RELEASE   = 2'd1;
    localparam logic [1:0] OP_HELD      = 2'd2;
    localparam logic [1:0] OP_NONE_HELD = 2'd3;

    // Result status codes.
    localparam logic [3:0] STAT_OK       = 4'd0;
    localparam logic [3:0] STAT_UNINIT   = 4'd1;
    localparam logic [3:0] STAT_REJECT   = 4'd2;
    localparam logic [3:0] STAT_CAPACITY = 4'd3;
    localparam logic [3:0] STAT_BADREL   = 4'd4;
    localparam logic [3:0] STAT_SWITCH   = 4'd5;
    localparam logic [3:0] STAT_NOTHELD  = 4'd6;
    localparam logic [3:0] STAT_NULL     = 4'd7;
    localparam logic [3:0] STAT_HALTED   = 4'd8;

    localparam int unsigned ID_W   = 32;
    localparam int unsigned RANK_W = 8;
    localparam int unsigned STAT_W = 4;
    localparam int unsigned OP_W   = 2;
    localparam int unsigned IN_W   = 48;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_TOP_RD,
        ST_TOP_CK,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [RANK_W-1:0] rank;
        logic              sched;
    } t_entry;

endpackage

// File: sv/lock_order_checker_top.sv
// Lock order checker: held-lock stack with a sequential walk over the entries.
//
// Input channel (s_axis): one word per lock event. tuser carries the operation
// (acquire, release, assert held, assert none held); tdata carries the lock
// identifier, rank, named bit and scheduler-kind bit.
// Output channel (m_axis): one word per input word with the status, the number
// of locks held afterwards and the lock named in a failure.
// The held stack lives in a memory with one write port and a registered read
// port. An acquire or an assert-held walks the stack one entry per cycle through one
// comparator; the walk stops early on a failed check or a match. A release or an
// assert-none-held with locks held reads the top entry; words decided without the
// stack go straight from acceptance to the result step. The result word turns
// valid in the cycle the block is ready again.
// The block accepts a new word only while its sequencer is idle.
// A synchronous active-low reset empties the stack and clears the halt flag;
// stack memory contents are not cleared. Any violation sets a sticky halt, and
// every later word answers with the halted status and changes nothing.
// The result sits in an output register; if the receiver stalls, the block
// holds in its final step until that register is free.
module lock_order_checker_top #(
    parameter int unsigned MAX_HELD = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    // lock_id [31:0], lock_rank [39:32], lock_named [40], lock_is_sched [41]
    input  logic [loc_pkg::IN_W-1:0] i_s_axis_tdata,
    // op [1:0]
    input  logic [loc_pkg::OP_W-1:0] i_s_axis_tuser,
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    // status [3:0], held_depth [DEPTH_W+3:4], reported_lock [DEPTH_W+35:DEPTH_W+4]
    output logic [((loc_pkg::STAT_W + $clog2(MAX_HELD + 1) + loc_pkg::ID_W + 7) / 8) * 8 - 1:0]
                                 o_m_axis_tdata
);

    localparam int unsigned DEPTH_W = $clog2(MAX_HELD + 1);
    localparam int unsigned IDX_W   = (MAX_HELD > 1) ? $clog2(MAX_HELD) : 1;
    localparam int unsigned RES_W   = loc_pkg::STAT_W + DEPTH_W + loc_pkg::ID_W;
    localparam int unsigned OUT_W   = ((RES_W + 7) / 8) * 8;

    loc_pkg::t_state r_state, n_state;

    loc_pkg::t_entry r_mem [MAX_HELD];
    loc_pkg::t_entry r_rd_data;

    logic [DEPTH_W-1:0]          r_depth;
    logic                        r_halted;
    logic [DEPTH_W-1:0]          r_idx, n_idx;
    logic                        r_pend, n_pend;
    logic                        r_pend_last, n_pend_last;

    logic [loc_pkg::OP_W-1:0]    r_op;
    logic [loc_pkg::ID_W-1:0]    r_id;
    logic [loc_pkg::RANK_W-1:0]  r_rank;
    logic                        r_sched;

    logic [loc_pkg::STAT_W-1:0]  r_status, n_status;
    logic [loc_pkg::ID_W-1:0]    r_rep, n_rep;
    logic                        r_push, n_push;
    logic                        r_pop, n_pop;

    logic                        r_out_valid;
    logic [OUT_W-1:0]            r_out_data;

    logic                        w_in_acc;
    logic                        w_go_done;
    logic                        w_go_walk;
    logic                        w_go_top;
    logic                        w_load;
    logic                        w_fail;
    logic [IDX_W-1:0]            w_rd_addr;
    logic [IDX_W-1:0]            w_top_idx;
    logic [DEPTH_W-1:0]          w_depth_after;

    logic [loc_pkg::OP_W-1:0]    w_op;
    logic [loc_pkg::ID_W-1:0]    w_id;
    logic [loc_pkg::RANK_W-1:0]  w_rank;
    logic                        w_named;
    logic                        w_sched;

    assign w_op    = i_s_axis_tuser;
    assign w_id    = i_s_axis_tdata[31:0];
    assign w_rank  = i_s_axis_tdata[39:32];
    assign w_named = i_s_axis_tdata[40];
    assign w_sched = i_s_axis_tdata[41];

    assign o_s_axis_tready = (r_state == loc_pkg::ST_IDLE);
    assign w_in_acc        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_top_idx       = IDX_W'(r_depth - DEPTH_W'(1));
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // An acquire fails on a duplicate, a higher held rank, or an equal rank
    // unless both are scheduler kind and the held identifier is lower.
    always_comb begin
        if (r_op == loc_pkg::OP_ACQUIRE) begin
            w_fail = (r_rd_data.id == r_id) || (r_rd_data.rank > r_rank) ||
                     ((r_rd_data.rank == r_rank) &&
                      !(r_rd_data.sched && r_sched && (r_rd_data.id < r_id)));
        end else begin
            w_fail = 1'b0;
        end
    end

    always_comb begin
        priority if (r_push) begin
            w_depth_after = r_depth + DEPTH_W'(1);
        end else if (r_pop) begin
            w_depth_after = r_depth - DEPTH_W'(1);
        end else begin
            w_depth_after = r_depth;
        end
    end

    // Sequencer outputs and result decisions.
    always_comb begin
        w_go_done   = 1'b0;
        w_go_walk   = 1'b0;
        w_go_top    = 1'b0;
        w_load      = 1'b0;
        w_rd_addr   = r_idx[IDX_W-1:0];
        n_idx       = r_idx;
        n_pend      = 1'b0;
        n_pend_last = 1'b0;
        n_status    = r_status;
        n_rep       = r_rep;
        n_push      = r_push;
        n_pop       = r_pop;
        unique case (r_state)
            loc_pkg::ST_IDLE: begin
                n_idx = '0;
                if (w_in_acc) begin
                    n_status = loc_pkg::STAT_OK;
                    n_rep    = '0;
                    n_push   = 1'b0;
                    n_pop    = 1'b0;
                    if (r_halted) begin
                        n_status  = loc_pkg::STAT_HALTED;
                        w_go_done = 1'b1;
                    end else begin
                        unique case (w_op)
                            loc_pkg::OP_ACQUIRE: begin
                                if (w_id == '0 || !w_named || w_rank == '0) begin
                                    n_status  = loc_pkg::STAT_UNINIT;
                                    n_rep     = w_id;
                                    w_go_done = 1'b1;
                                end else if (r_depth >= DEPTH_W'(MAX_HELD)) begin
                                    n_status  = loc_pkg::STAT_CAPACITY;
                                    n_rep     = w_id;
                                    w_go_done = 1'b1;
                                end else if (r_depth == '0) begin
                                    n_push    = 1'b1;
                                    w_go_done = 1'b1;
                                end else begin
                                    w_go_walk = 1'b1;
                                end
                            end
                            loc_pkg::OP_RELEASE: begin
                                if (r_depth == '0) begin
                                    n_status  = loc_pkg::STAT_BADREL;
                                    n_rep     = w_id;
                                    w_go_done = 1'b1;
                                end else begin
                                    w_go_top = 1'b1;
                                end
                            end
                            loc_pkg::OP_HELD: begin
                                if (w_id == '0) begin
                                    n_status  = loc_pkg::STAT_NULL;
                                    w_go_done = 1'b1;
                                end else if (r_depth == '0) begin
                                    n_status  = loc_pkg::STAT_NOTHELD;
                                    n_rep     = w_id;
                                    w_go_done = 1'b1;
                                end else begin
                                    w_go_walk = 1'b1;
                                end
                            end
                            loc_pkg::OP_NONE_HELD: begin
                                if (r_depth == '0) begin
                                    w_go_done = 1'b1;
                                end else begin
                                    w_go_top = 1'b1;
                                end
                            end
                            default: begin
                                w_go_done = 1'b1;
                            end
                        endcase
                    end
                end
            end
            loc_pkg::ST_WALK: begin
                // One entry is read per cycle; its data is checked once the registered read returns it.
                if (r_idx < r_depth) begin
                    n_idx       = r_idx + DEPTH_W'(1);
                    n_pend      = 1'b1;
                    n_pend_last = (r_idx == r_depth - DEPTH_W'(1));
                end
                if (r_pend) begin
                    if (r_op == loc_pkg::OP_ACQUIRE) begin
                        if (w_fail) begin
                            n_status  = loc_pkg::STAT_REJECT;
                            n_rep     = r_id;
                            w_go_done = 1'b1;
                        end else if (r_pend_last) begin
                            n_push    = 1'b1;
                            w_go_done = 1'b1;
                        end
                    end else begin
                        if (r_rd_data.id == r_id) begin
                            w_go_done = 1'b1;
                        end else if (r_pend_last) begin
                            n_status  = loc_pkg::STAT_NOTHELD;
                            n_rep     = r_id;
                            w_go_done = 1'b1;
                        end
                    end
                end
            end
            loc_pkg::ST_TOP_RD: begin
                w_rd_addr = w_top_idx;
            end
            loc_pkg::ST_TOP_CK: begin
                if (r_op == loc_pkg::OP_RELEASE) begin
                    if (r_rd_data.id == r_id) begin
                        n_pop = 1'b1;
                    end else begin
                        n_status = loc_pkg::STAT_BADREL;
                        n_rep    = r_id;
                    end
                end else begin
                    n_status = loc_pkg::STAT_SWITCH;
                    n_rep    = r_rd_data.id;
                end
            end
            loc_pkg::ST_DONE: begin
                w_load = !r_out_valid || i_m_axis_tready;
            end
            default: begin
                w_load = 1'b0;
            end
        endcase
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            loc_pkg::ST_IDLE: begin
                priority if (w_go_done) begin
                    n_state = loc_pkg::ST_DONE;
                end else if (w_go_walk) begin
                    n_state = loc_pkg::ST_WALK;
                end else if (w_go_top) begin
                    n_state = loc_pkg::ST_TOP_RD;
                end else begin
                    n_state = loc_pkg::ST_IDLE;
                end
            end
            loc_pkg::ST_WALK: begin
                if (w_go_done) begin
                    n_state = loc_pkg::ST_DONE;
                end
            end
            loc_pkg::ST_TOP_RD: n_state = loc_pkg::ST_TOP_CK;
            loc_pkg::ST_TOP_CK: n_state = loc_pkg::ST_DONE;
            loc_pkg::ST_DONE: begin
                if (w_load) begin
                    n_state = loc_pkg::ST_IDLE;
                end
            end
            default: n_state = loc_pkg::ST_IDLE;
        endcase
    end

    // Stack memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (r_state == loc_pkg::ST_DONE && w_load && r_push) begin
            r_mem[r_depth[IDX_W-1:0]] <= '{id: r_id, rank: r_rank, sched: r_sched};
        end
        r_rd_data <= r_mem[w_rd_addr];
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_op    <= w_op;
            r_id    <= w_id;
            r_rank  <= w_rank;
            r_sched <= w_sched;
        end
        r_idx       <= n_idx;
        r_pend_last <= n_pend_last;
        r_status    <= n_status;
        r_rep       <= n_rep;
        r_push      <= n_push;
        r_pop       <= n_pop;
        if (r_state == loc_pkg::ST_DONE && w_load) begin
            r_out_data <= OUT_W'({r_rep, w_depth_after, r_status});
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= loc_pkg::ST_IDLE;
            r_depth     <= '0;
            r_halted    <= 1'b0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
            if (r_state == loc_pkg::ST_DONE && w_load) begin
                r_depth     <= w_depth_after;
                r_out_valid <= 1'b1;
                if (r_status != loc_pkg::STAT_OK && r_status != loc_pkg::STAT_HALTED) begin
                    r_halted <= 1'b1;
                end
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= DEPTH_W'(MAX_HELD))
        else $error("held depth exceeds stack size");

    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |=> r_halted)
        else $error("halt flag cleared without reset");

    a_depth_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_depth != $past(r_depth)) |-> ($past(r_state) == loc_pkg::ST_DONE))
        else $error("held depth changed outside result commit");

    a_fail_halts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == loc_pkg::ST_DONE && w_load && r_status != loc_pkg::STAT_OK)
        |=> r_halted)
        else $error("failure did not set halt");

    a_halted_no_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_halted && r_state == loc_pkg::ST_DONE) |-> (!r_push && !r_pop))
        else $error("stack changed while halted");

endmodule
